### sv/ordered_list_insert_remove_defines.svh
// assertion macros shared by the ordered list checker
`ifndef ORDERED_LIST_INSERT_REMOVE_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define OLIR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ordered list check failed");

// antecedent implies consequent in the next cycle
`define OLIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ordered list check failed");

`endif

### sv/olir_pkg.sv
// types and constants of the ordered list block
package olir_pkg;

	localparam int ACTION_W = 3;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_INSERT = 3'd2,
		ACT_REMOVE = 3'd3,
		ACT_GET    = 3'd4,
		ACT_SET    = 3'd5,
		ACT_CLEAR  = 3'd6
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// memory write address source
	typedef enum logic [1:0] {
		WA_COUNT,
		WA_PTR,
		WA_POS
	} wa_sel_t;

	// memory read address source
	typedef enum logic [1:0] {
		RA_PTR_DEC,
		RA_PTR_INC,
		RA_POS
	} ra_sel_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_LOAD_COUNT,
		PTR_LOAD_POS,
		PTR_DEC,
		PTR_INC
	} ptr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	typedef struct packed {
		logic    take;
		logic    wr_en;
		wa_sel_t wa_sel;
		ra_sel_t ra_sel;
		ptr_op_t ptr_op;
		cnt_op_t cnt_op;
		logic    emit;
		logic    use_read;
		status_t status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic                full;
		logic                empty;
		logic                ins_pos_bad;
		logic                acc_pos_bad;
		logic                ptr_gt_pos;
		logic                ptr_next_lt_count;
		logic                out_free;
	} dp_stat_t;

endpackage

### sv/olir_req_if.sv
// request channel of the ordered list
interface olir_req_if;
	logic                                       valid;
	logic                                       ready;
	logic        [olir_pkg::ACTION_W-1:0]       action;
	logic        [olir_pkg::POS_W-1:0]          position;
	logic signed [olir_pkg::VALUE_W-1:0]        value;

	modport source (output valid, output action, output position, output value, input ready);
	modport sink   (input valid, input action, input position, input value, output ready);
endinterface

### sv/olir_rsp_if.sv
// response channel of the ordered list
interface olir_rsp_if;
	logic                                       valid;
	logic                                       ready;
	logic signed [olir_pkg::VALUE_W-1:0]        read_value;
	logic        [olir_pkg::STATUS_W-1:0]       status;
	logic        [olir_pkg::COUNT_W-1:0]        count;

	modport source (output valid, output read_value, output status, output count, input ready);
	modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

### sv/ordered_list_insert_remove.sv
// Ordered list of CAPACITY signed words held in a memory with registered
// read data. One request is worked at a time; each transfer returns one result with a
// status and the entry count after the request. A request is decoded after its transfer;
// get then reads the memory, insert and remove run a move loop over the entries that
// move, insert then writes the new entry, and the result register is loaded last.
// The move loop works each entry through a position check, a memory read and a write.
// The load waits while the previous result still sits unaccepted in the output register.
// A new request is taken while the previous result still waits in the output register.
module ordered_list_insert_remove #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	olir_req_if.sink   req,
	olir_rsp_if.source rsp
);

	olir_pkg::ctrl_cmd_t cmd;
	olir_pkg::dp_stat_t  dp;
	logic                ctrl_ready;
	logic                in_fire;

	assign req.ready = ctrl_ready;
	assign in_fire   = req.valid && ctrl_ready;

	olir_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.dp      (dp),
		.ready   (ctrl_ready),
		.cmd     (cmd)
	);

	olir_dpath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.dp     (dp)
	);

endmodule

### sv/olir_ctrl.sv
// sequencer that walks each request through decode, shift loops and response
module olir_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  olir_pkg::dp_stat_t  dp,
	output logic                ready,
	output olir_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_CHK,
		S_INS_RD,
		S_INS_WR,
		S_INS_PUT,
		S_REM_CHK,
		S_REM_RD,
		S_REM_WR,
		S_GET_RD,
		S_RESP
	} state_t;

	state_t              state_q, state_d;
	olir_pkg::status_t   st_q, st_d;
	logic                rdv_q, rdv_d;

	assign ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		st_d         = st_q;
		rdv_d        = rdv_q;
		cmd          = '0;
		cmd.wa_sel   = olir_pkg::WA_POS;
		cmd.ra_sel   = olir_pkg::RA_POS;
		cmd.ptr_op   = olir_pkg::PTR_HOLD;
		cmd.cnt_op   = olir_pkg::CNT_HOLD;
		cmd.status   = st_q;
		cmd.use_read = rdv_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = in_fire;
				if (in_fire) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				st_d    = olir_pkg::ST_OK;
				rdv_d   = 1'b0;
				state_d = S_RESP;
				case (dp.act)
					olir_pkg::ACT_PUSH: begin
						if (dp.full) begin
							st_d = olir_pkg::ST_FULL;
						end else begin
							cmd.wr_en  = 1'b1;
							cmd.wa_sel = olir_pkg::WA_COUNT;
							cmd.cnt_op = olir_pkg::CNT_INC;
						end
					end
					olir_pkg::ACT_POP: begin
						if (dp.empty) begin
							st_d = olir_pkg::ST_EMPTY;
						end else begin
							cmd.cnt_op = olir_pkg::CNT_DEC;
						end
					end
					olir_pkg::ACT_INSERT: begin
						// position is checked before fullness
						priority if (dp.ins_pos_bad) begin
							st_d = olir_pkg::ST_BADPOS;
						end else if (dp.full) begin
							st_d = olir_pkg::ST_FULL;
						end else begin
							cmd.ptr_op = olir_pkg::PTR_LOAD_COUNT;
							state_d    = S_INS_CHK;
						end
					end
					olir_pkg::ACT_REMOVE: begin
						if (dp.acc_pos_bad) begin
							st_d = olir_pkg::ST_BADPOS;
						end else begin
							cmd.ptr_op = olir_pkg::PTR_LOAD_POS;
							state_d    = S_REM_CHK;
						end
					end
					olir_pkg::ACT_GET: begin
						if (dp.acc_pos_bad) begin
							st_d = olir_pkg::ST_BADPOS;
						end else begin
							rdv_d   = 1'b1;
							state_d = S_GET_RD;
						end
					end
					olir_pkg::ACT_SET: begin
						if (dp.acc_pos_bad) begin
							st_d = olir_pkg::ST_BADPOS;
						end else begin
							cmd.wr_en  = 1'b1;
							cmd.wa_sel = olir_pkg::WA_POS;
						end
					end
					olir_pkg::ACT_CLEAR: begin
						cmd.cnt_op = olir_pkg::CNT_CLR;
					end
					default: begin
						// unused code is a no-op
					end
				endcase
			end
			S_INS_CHK: begin
				state_d = dp.ptr_gt_pos ? S_INS_RD : S_INS_PUT;
			end
			S_INS_RD: begin
				cmd.ra_sel = olir_pkg::RA_PTR_DEC;
				state_d    = S_INS_WR;
			end
			S_INS_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = olir_pkg::WA_PTR;
				cmd.ptr_op = olir_pkg::PTR_DEC;
				state_d    = S_INS_CHK;
			end
			S_INS_PUT: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = olir_pkg::WA_POS;
				cmd.cnt_op = olir_pkg::CNT_INC;
				state_d    = S_RESP;
			end
			S_REM_CHK: begin
				if (dp.ptr_next_lt_count) begin
					state_d = S_REM_RD;
				end else begin
					cmd.cnt_op = olir_pkg::CNT_DEC;
					state_d    = S_RESP;
				end
			end
			S_REM_RD: begin
				cmd.ra_sel = olir_pkg::RA_PTR_INC;
				state_d    = S_REM_WR;
			end
			S_REM_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = olir_pkg::WA_PTR;
				cmd.ptr_op = olir_pkg::PTR_INC;
				state_d    = S_REM_CHK;
			end
			S_GET_RD: begin
				cmd.ra_sel = olir_pkg::RA_POS;
				state_d    = S_RESP;
			end
			S_RESP: begin
				// wait for the result register to free up
				if (dp.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= olir_pkg::ST_OK;
			rdv_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			rdv_q   <= rdv_d;
		end
	end

endmodule

### sv/olir_dpath.sv
// entry memory, count, shift pointer, request and result registers
module olir_dpath #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	olir_req_if.sink            req,
	olir_rsp_if.source          rsp,
	input  olir_pkg::ctrl_cmd_t cmd,
	output olir_pkg::dp_stat_t  dp
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > olir_pkg::POS_W) ? CW : olir_pkg::POS_W;

	logic [DATA_WIDTH-1:0]             mem [CAPACITY];
	logic [DATA_WIDTH-1:0]             rdata_q;

	logic [olir_pkg::ACTION_W-1:0]     act_q;
	logic [olir_pkg::POS_W-1:0]        pos_q;
	logic [DATA_WIDTH-1:0]             word_q;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     ptr_q;

	logic                              rsp_valid_q;
	logic signed [olir_pkg::VALUE_W-1:0] rv_q;
	olir_pkg::status_t                 st_q;
	logic [olir_pkg::COUNT_W-1:0]      cnt_out_q;

	logic signed [63:0]                val_wide;
	logic signed [DATA_WIDTH-1:0]      rd_word;
	logic signed [63:0]                rd_wide;
	logic [CW-1:0]                     ptr_inc;
	logic [CW-1:0]                     ptr_dec;
	logic [CMPW-1:0]                   pos_x;
	logic [CMPW-1:0]                   cnt_x;
	logic [CMPW-1:0]                   ptr_x;
	logic [CMPW-1:0]                   ptr_inc_x;
	logic [AW-1:0]                     wa;
	logic [AW-1:0]                     ra;
	logic [DATA_WIDTH-1:0]             wd;

	// input word is truncated or sign-extended to the stored width
	assign val_wide  = 64'(req.value);
	assign rd_word   = rdata_q;
	assign rd_wide   = 64'(rd_word);

	assign ptr_inc   = ptr_q + 1'b1;
	assign ptr_dec   = ptr_q - 1'b1;
	assign pos_x     = CMPW'(pos_q);
	assign cnt_x     = CMPW'(count_q);
	assign ptr_x     = CMPW'(ptr_q);
	assign ptr_inc_x = CMPW'(ptr_inc);

	assign dp.act               = act_q;
	assign dp.full              = (count_q == CW'(CAPACITY));
	assign dp.empty             = (count_q == '0);
	assign dp.ins_pos_bad       = (pos_x > cnt_x);
	assign dp.acc_pos_bad       = (pos_x >= cnt_x);
	assign dp.ptr_gt_pos        = (ptr_x > pos_x);
	assign dp.ptr_next_lt_count = (ptr_inc_x < cnt_x);
	assign dp.out_free          = !rsp_valid_q || rsp.ready;

	always_comb begin
		unique case (cmd.wa_sel)
			olir_pkg::WA_COUNT: wa = count_q[AW-1:0];
			olir_pkg::WA_PTR:   wa = ptr_q[AW-1:0];
			default:            wa = AW'(pos_q);
		endcase
		unique case (cmd.ra_sel)
			olir_pkg::RA_PTR_DEC: ra = ptr_dec[AW-1:0];
			olir_pkg::RA_PTR_INC: ra = ptr_inc[AW-1:0];
			default:              ra = AW'(pos_q);
		endcase
		wd = (cmd.wa_sel == olir_pkg::WA_PTR) ? rdata_q : word_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			act_q  <= req.action;
			pos_q  <= req.position;
			word_q <= val_wide[DATA_WIDTH-1:0];
		end
		unique case (cmd.ptr_op)
			olir_pkg::PTR_LOAD_COUNT: ptr_q <= count_q;
			olir_pkg::PTR_LOAD_POS:   ptr_q <= CW'(pos_q);
			olir_pkg::PTR_DEC:        ptr_q <= ptr_dec;
			olir_pkg::PTR_INC:        ptr_q <= ptr_inc;
			default:                  ptr_q <= ptr_q;
		endcase
		if (cmd.emit) begin
			rv_q      <= cmd.use_read ? rd_wide[olir_pkg::VALUE_W-1:0] : '0;
			st_q      <= cmd.status;
			cnt_out_q <= olir_pkg::COUNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (cmd.cnt_op)
				olir_pkg::CNT_INC: count_q <= count_q + 1'b1;
				olir_pkg::CNT_DEC: count_q <= count_q - 1'b1;
				olir_pkg::CNT_CLR: count_q <= '0;
				default:           count_q <= count_q;
			endcase
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rv_q;
	assign rsp.status     = st_q;
	assign rsp.count      = cnt_out_q;

endmodule

### sv/olir_checker.sv
// port-level checks of the ordered list and their bind
`include "ordered_list_insert_remove_defines.svh"

module olir_checker #(
	parameter int CAPACITY = 64
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic [olir_pkg::VALUE_W-1:0]       rsp_read_value,
	input logic [olir_pkg::STATUS_W-1:0]      rsp_status,
	input logic [olir_pkg::COUNT_W-1:0]       rsp_count
);

	// a result waiting for the sink stays up
	`OLIR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// only a successful get carries data
	`OLIR_ASSERT_SAME(a_rd_zero, clk, arst_n, rsp_valid && (rsp_status != olir_pkg::ST_OK), rsp_read_value == '0)

	// empty flag only when nothing is held
	`OLIR_ASSERT_SAME(a_empty_cnt, clk, arst_n, rsp_valid && (rsp_status == olir_pkg::ST_EMPTY), rsp_count == '0)

	// full flag only at capacity
	`OLIR_ASSERT_SAME(a_full_cnt, clk, arst_n, rsp_valid && (rsp_status == olir_pkg::ST_FULL), rsp_count == olir_pkg::COUNT_W'(CAPACITY))

	// reported count never exceeds capacity
	`OLIR_ASSERT_SAME(a_cnt_max, clk, arst_n, rsp_valid, 32'(rsp_count) <= 32'(CAPACITY))

endmodule

bind ordered_list_insert_remove olir_checker #(
	.CAPACITY (CAPACITY)
) u_olir_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value),
	.rsp_status     (rsp.status),
	.rsp_count      (rsp.count)
);

### tb/sv/tb_top.sv
// ordered list testbench: directed request table, then random request episodes checked against a list predictor
`timescale 1ns / 100ps

module tb_top;
	import olir_pkg::*;

	localparam int LIST_CAP    = 64;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int DRAIN_WAIT  = 200;
	localparam int PHASE_ITEMS = 584;

	localparam logic [ACTION_W-1:0] ACT_NOP = 3'd7;
	localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic signed [VALUE_W-1:0] rd;
		status_t                   st;
		logic [COUNT_W-1:0]        cnt;
	} list_rsp_t;

	typedef struct packed {
		logic [ACTION_W-1:0]       act;
		logic [POS_W-1:0]          pos;
		logic signed [VALUE_W-1:0] val;
		logic                      fixed;
		list_rsp_t                 rsp;
	} dir_row_t;

	// rows with fixed set carry a typed-in result, the rest go through the predictor
	localparam int DIR_N = 26;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{ACT_POP,    7'd0,   32'sd0,        1'b1, '{32'sd0, ST_EMPTY,  7'd0}},
		'{ACT_GET,    7'd0,   32'sd0,        1'b1, '{32'sd0, ST_BADPOS, 7'd0}},
		'{ACT_REMOVE, 7'd0,   32'sd0,        1'b1, '{32'sd0, ST_BADPOS, 7'd0}},
		'{ACT_SET,    7'd0,   -32'sd1,       1'b1, '{32'sd0, ST_BADPOS, 7'd0}},
		'{ACT_INSERT, 7'd1,   32'sd7,        1'b1, '{32'sd0, ST_BADPOS, 7'd0}},
		'{ACT_INSERT, 7'd127, -32'sd1,       1'b1, '{32'sd0, ST_BADPOS, 7'd0}},
		'{ACT_INSERT, 7'd0,   WORD_MIN,      1'b1, '{32'sd0, ST_OK,     7'd1}},
		'{ACT_PUSH,   7'd127, WORD_MAX,      1'b1, '{32'sd0, ST_OK,     7'd2}},
		'{ACT_GET,    7'd0,   32'sd0,        1'b1, '{WORD_MIN, ST_OK,   7'd2}},
		'{ACT_GET,    7'd1,   32'sd0,        1'b1, '{WORD_MAX, ST_OK,   7'd2}},
		'{ACT_INSERT, 7'd1,   -32'sd1,       1'b0, '0},
		'{ACT_INSERT, 7'd3,   32'sd0,        1'b0, '0},
		'{ACT_GET,    7'd1,   32'sd0,        1'b0, '0},
		'{ACT_SET,    7'd0,   32'sh5555_5555, 1'b0, '0},
		'{ACT_GET,    7'd0,   32'sd0,        1'b0, '0},
		'{ACT_GET,    7'd4,   32'sd0,        1'b1, '{32'sd0, ST_BADPOS, 7'd4}},
		'{ACT_REMOVE, 7'd4,   32'sd0,        1'b1, '{32'sd0, ST_BADPOS, 7'd4}},
		'{ACT_INSERT, 7'd5,   32'sd9,        1'b1, '{32'sd0, ST_BADPOS, 7'd4}},
		'{ACT_REMOVE, 7'd0,   32'sd0,        1'b0, '0},
		'{ACT_NOP,    7'd127, -32'sd1,       1'b1, '{32'sd0, ST_OK,     7'd3}},
		'{ACT_REMOVE, 7'd2,   32'sd0,        1'b0, '0},
		'{ACT_POP,    7'd0,   32'sd0,        1'b0, '0},
		'{ACT_CLEAR,  7'd0,   32'sd0,        1'b1, '{32'sd0, ST_OK,     7'd0}},
		'{ACT_GET,    7'd0,   32'sd0,        1'b1, '{32'sd0, ST_BADPOS, 7'd0}},
		'{ACT_PUSH,   7'd0,   32'shaaaa_aaaa, 1'b0, '0},
		'{ACT_GET,    7'd0,   32'sd0,        1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	olir_req_if req_ch ();
	olir_rsp_if rsp_ch ();

	ordered_list_insert_remove #(
		.CAPACITY   (LIST_CAP),
		.DATA_WIDTH (VALUE_W)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #6 clk = ~clk;

	// predicted list contents
	logic signed [VALUE_W-1:0] list_mem [LIST_CAP];
	int list_len = 0;

	list_rsp_t expected_rsp [$];
	int send_idle_pct = 32;
	int recv_idle_pct = 53;
	int error_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int cycle_count = 0;

	function automatic void apply_list_request(input logic [ACTION_W-1:0] act,
			input logic [POS_W-1:0] pos, input logic signed [VALUE_W-1:0] val,
			output list_rsp_t res);
		int p;
		p = int'(pos);
		res = '{32'sd0, ST_OK, 7'd0};
		case (act)
			ACT_PUSH: begin
				if (list_len >= LIST_CAP) res.st = ST_FULL;
				else begin
					list_mem[list_len] = val;
					list_len++;
				end
			end
			ACT_POP: begin
				if (list_len == 0) res.st = ST_EMPTY;
				else list_len--;
			end
			ACT_INSERT: begin
				// position is checked before fullness
				if (p > list_len) res.st = ST_BADPOS;
				else if (list_len >= LIST_CAP) res.st = ST_FULL;
				else begin
					for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
					list_mem[p] = val;
					list_len++;
				end
			end
			ACT_REMOVE: begin
				if (p >= list_len) res.st = ST_BADPOS;
				else begin
					for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			ACT_GET: begin
				if (p >= list_len) res.st = ST_BADPOS;
				else res.rd = list_mem[p];
			end
			ACT_SET: begin
				if (p >= list_len) res.st = ST_BADPOS;
				else list_mem[p] = val;
			end
			ACT_CLEAR: list_len = 0;
			default: ;
		endcase
		res.cnt = COUNT_W'(list_len);
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_request(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
			input logic signed [VALUE_W-1:0] val, input logic fixed = 1'b0,
			input list_rsp_t fixed_rsp = '0);
		list_rsp_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.action   <= act;
		req_ch.position <= pos;
		req_ch.value    <= val;
		do @(posedge clk); while (!req_ch.ready);
		apply_list_request(act, pos, val, predicted);
		expected_rsp.push_back(fixed ? fixed_rsp : predicted);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic fill_list();
		while (list_len < LIST_CAP) begin
			if ($urandom_range(1))
				send_request(ACT_PUSH, POS_W'($urandom_range(127)), pick_word());
			else
				send_request(ACT_INSERT, POS_W'($urandom_range(list_len)), pick_word());
		end
		// a few more on the full list, valid and bad positions
		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(2))
				0: send_request(ACT_PUSH, POS_W'($urandom_range(127)), pick_word());
				1: send_request(ACT_INSERT, POS_W'($urandom_range(LIST_CAP)), pick_word());
				default: send_request(ACT_INSERT,
					POS_W'($urandom_range(LIST_CAP + 1, 127)), pick_word());
			endcase
		end
	endtask

	task automatic drain_list();
		while (list_len > 0) begin
			if ($urandom_range(1))
				send_request(ACT_POP, POS_W'($urandom_range(127)), pick_word());
			else
				send_request(ACT_REMOVE, POS_W'($urandom_range(list_len - 1)), pick_word());
		end
		repeat ($urandom_range(1, 2)) begin
			case ($urandom_range(3))
				0: send_request(ACT_POP, POS_W'($urandom_range(127)), pick_word());
				1: send_request(ACT_REMOVE, POS_W'($urandom_range(127)), pick_word());
				2: send_request(ACT_GET, POS_W'($urandom_range(127)), pick_word());
				default: send_request(ACT_SET, POS_W'($urandom_range(127)), pick_word());
			endcase
		end
	endtask

	task automatic mixed_request();
		int r;
		int p_ins;
		int p_acc;
		r = $urandom_range(99);
		// mostly valid positions, one in ten anywhere in the field
		p_ins = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(list_len);
		if (list_len == 0 || $urandom_range(9) == 0) p_acc = $urandom_range(127);
		else p_acc = $urandom_range(list_len - 1);
		if (r < 15) send_request(ACT_PUSH, POS_W'($urandom_range(127)), pick_word());
		else if (r < 27) send_request(ACT_POP, POS_W'($urandom_range(127)), pick_word());
		else if (r < 42) send_request(ACT_INSERT, POS_W'(p_ins), pick_word());
		else if (r < 55) send_request(ACT_REMOVE, POS_W'(p_acc), pick_word());
		else if (r < 72) send_request(ACT_GET, POS_W'(p_acc), pick_word());
		else if (r < 85) send_request(ACT_SET, POS_W'(p_acc), pick_word());
		else if (r < 88) send_request(ACT_CLEAR, POS_W'($urandom_range(127)), pick_word());
		else if (r < 90) send_request(ACT_NOP, POS_W'($urandom_range(127)), pick_word());
		else send_request(ACTION_W'($urandom_range(7)), POS_W'($urandom_range(127)), $urandom);
	endtask

	task automatic run_random_phase(input int n_items);
		int stop_at;
		int mode;
		stop_at = requests_sent + n_items;
		while (requests_sent < stop_at) begin
			mode = $urandom_range(9);
			if (mode < 2) fill_list();
			else if (mode < 4) drain_list();
			else repeat ($urandom_range(5, 40)) mixed_request();
		end
	endtask

	always @(negedge clk) rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : rsp_check
		list_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsp.size() == 0) begin
				$error("result transfer with nothing expected: read_value %0d status %0d count %0d",
					rsp_ch.read_value, rsp_ch.status, rsp_ch.count);
				error_count++;
			end else begin
				want = expected_rsp.pop_front();
				results_checked++;
				status_seen[want.st]++;
				if (rsp_ch.read_value !== want.rd) begin
					$error("read_value: expected %0d, actual %0d", want.rd, rsp_ch.read_value);
					error_count++;
				end
				if (rsp_ch.status !== want.st) begin
					$error("status: expected %0d, actual %0d", want.st, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.count !== want.cnt) begin
					$error("count: expected %0d, actual %0d", want.cnt, rsp_ch.count);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_rsp.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		req_ch.valid    = 1'b0;
		req_ch.action   = ACT_PUSH;
		req_ch.position = '0;
		req_ch.value    = '0;
		rsp_ch.ready    = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_request(DIR_ROWS[i].act, DIR_ROWS[i].pos, DIR_ROWS[i].val,
				DIR_ROWS[i].fixed, DIR_ROWS[i].rsp);

		run_random_phase(PHASE_ITEMS);
		send_idle_pct = 53;
		recv_idle_pct = 32;
		run_random_phase(PHASE_ITEMS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_phase(PHASE_ITEMS);
		req_ch.valid <= 1'b0;

		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d requests sent, %0d results checked over three handshake pressure phases",
			requests_sent, results_checked);
		$display("status mix: ok %0d, empty %0d, bad position %0d, full %0d",
			status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BADPOS],
			status_seen[ST_FULL]);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### ordered_list_insert_remove.f
+incdir+sv
sv/olir_pkg.sv
sv/olir_req_if.sv
sv/olir_rsp_if.sv
sv/olir_ctrl.sv
sv/olir_dpath.sv
sv/ordered_list_insert_remove.sv
sv/olir_checker.sv
tb/sv/tb_top.sv
